### src/stb_pkg.sv
`default_nettype none
package stb_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_part0;
        logic [63:0] key_part1;
        logic [31:0] key_part2;
        logic [63:0] kind_in0;
        logic [63:0] kind_in1;
        logic [31:0] kind_in2;
        logic [63:0] payload_in0;
        logic [63:0] payload_in1;
        logic [31:0] payload_in2;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] kind_out0;
        logic [63:0] kind_out1;
        logic [31:0] kind_out2;
        logic [63:0] payload_out0;
        logic [63:0] payload_out1;
        logic [31:0] payload_out2;
        logic [6:0]  entries_used;
    } t_rsp;

    typedef struct packed {
        logic [63:0] part0;
        logic [63:0] part1;
        logic [31:0] part2;
    } t_name;

    typedef struct packed {
        logic [63:0] kind0;
        logic [63:0] kind1;
        logic [31:0] kind2;
        logic [63:0] payload0;
        logic [63:0] payload1;
        logic [31:0] payload2;
    } t_attr;

endpackage
`default_nettype wire

### src/stb_ram.sv
`default_nettype none
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### src/stb_norm.sv
`default_nettype none
module stb_norm (
    input  wire stb_pkg::t_name i_name,
    output stb_pkg::t_name      o_name
);
    import stb_pkg::*;

    localparam int NBYTES = 20;

    logic [NBYTES*8-1:0] flat_in;
    logic [NBYTES*8-1:0] flat_out;
    logic                seen;

    assign flat_in = {i_name.part2, i_name.part1, i_name.part0};

    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < NBYTES; i++) begin
            flat_out[i*8 +: 8] = seen ? 8'h00 : flat_in[i*8 +: 8];
            seen = seen | (flat_in[i*8 +: 8] == 8'h00);
        end
    end

    assign o_name.part0 = flat_out[63:0];
    assign o_name.part1 = flat_out[127:64];
    assign o_name.part2 = flat_out[159:128];

endmodule
`default_nettype wire

### src/symbol_table_insert_search_delete.sv
`default_nettype none
// Channel    Ports                         Handshake
// request    start, busy, i_req            taken when start & !busy
// result     o_strobe, o_rsp               one cycle per strobe, always taken
//
// Insert, full and unknown actions, and a search or delete on an empty table,
// answer in the cycle after the request. Search and delete read one entry per
// cycle from the name and attribute RAMs, whose reads are registered.
// Delete then moves each later entry down one slot, one per cycle.
// Synchronous reset empties the table at once; RAM contents are not cleared.
// busy is high from a search or delete request on a non-empty table until its result strobe.
module symbol_table_insert_search_delete #(
    parameter int MAX_ENTRIES = stb_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire stb_pkg::t_req i_req,
    output logic               busy,
    output logic               o_strobe,
    output stb_pkg::t_rsp      o_rsp
);
    import stb_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] last;
    t_name         r_key;
    logic          r_del;
    logic          r_strobe, n_strobe;
    t_rsp          r_rsp, n_rsp;

    t_name         key_norm;
    t_name         in_name;
    t_attr         in_attr;
    logic [CW-1:0] rd_idx;
    t_name         rd_name;
    t_attr         rd_attr;
    logic          wr_en;
    logic [CW-1:0] wr_idx;
    t_name         wr_name;
    t_attr         wr_attr;

    assign in_name.part0 = i_req.key_part0;
    assign in_name.part1 = i_req.key_part1;
    assign in_name.part2 = i_req.key_part2;

    assign in_attr.kind0    = i_req.kind_in0;
    assign in_attr.kind1    = i_req.kind_in1;
    assign in_attr.kind2    = i_req.kind_in2;
    assign in_attr.payload0 = i_req.payload_in0;
    assign in_attr.payload1 = i_req.payload_in1;
    assign in_attr.payload2 = i_req.payload_in2;

    stb_norm u_norm (
        .i_name (in_name),
        .o_name (key_norm)
    );

    stb_ram #(
        .WIDTH ($bits(t_name)),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_name_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx[AW-1:0]),
        .i_wr_data (wr_name),
        .i_rd_addr (rd_idx[AW-1:0]),
        .o_rd_data (rd_name)
    );

    stb_ram #(
        .WIDTH ($bits(t_attr)),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_attr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx[AW-1:0]),
        .i_wr_data (wr_attr),
        .i_rd_addr (rd_idx[AW-1:0]),
        .o_rd_data (rd_attr)
    );

    assign last = CW'(r_count - CW'(1));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        rd_idx   = r_idx;
        wr_en    = 1'b0;
        wr_idx   = r_idx;
        wr_name  = rd_name;
        wr_attr  = rd_attr;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rsp = '0;
                    case (i_req.action)
                        ACT_INSERT: begin
                            n_strobe = 1'b1;
                            if (r_count >= CW'(MAX_ENTRIES)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                wr_idx       = r_count;
                                wr_name      = key_norm;
                                wr_attr      = in_attr;
                                n_count      = CW'(r_count + CW'(1));
                                n_rsp.status = ST_INSERTED;
                            end
                        end
                        ACT_SEARCH, ACT_DELETE: begin
                            if (r_count == '0) begin
                                n_strobe     = 1'b1;
                                n_rsp.status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                                n_idx   = '0;
                                rd_idx  = '0;
                            end
                        end
                        default: begin
                            n_strobe     = 1'b1;
                            n_rsp.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_name == r_key) begin
                    if (!r_del) begin
                        n_strobe           = 1'b1;
                        n_state            = S_IDLE;
                        n_rsp              = '0;
                        n_rsp.status       = ST_FOUND;
                        n_rsp.kind_out0    = rd_attr.kind0;
                        n_rsp.kind_out1    = rd_attr.kind1;
                        n_rsp.kind_out2    = rd_attr.kind2;
                        n_rsp.payload_out0 = rd_attr.payload0;
                        n_rsp.payload_out1 = rd_attr.payload1;
                        n_rsp.payload_out2 = rd_attr.payload2;
                    end else if (r_idx == last) begin
                        n_strobe     = 1'b1;
                        n_state      = S_IDLE;
                        n_count      = last;
                        n_rsp        = '0;
                        n_rsp.status = ST_DELETED;
                    end else begin
                        n_state = S_SHIFT;
                        rd_idx  = CW'(r_idx + CW'(1));
                    end
                end else if (r_idx == last) begin
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                    n_rsp        = '0;
                    n_rsp.status = ST_NOT_FOUND;
                end else begin
                    n_idx  = CW'(r_idx + CW'(1));
                    rd_idx = CW'(r_idx + CW'(1));
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_idx  = r_idx;
                wr_name = rd_name;
                wr_attr = rd_attr;
                if (CW'(r_idx + CW'(1)) == last) begin
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                    n_count      = last;
                    n_rsp        = '0;
                    n_rsp.status = ST_DELETED;
                end else begin
                    n_idx  = CW'(r_idx + CW'(1));
                    rd_idx = CW'(r_idx + CW'(2));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.entries_used = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
            r_rsp    <= n_rsp;
            if (start && r_state == S_IDLE) begin
                r_key <= key_norm;
                r_del <= (i_req.action == ACT_DELETE);
            end
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
`default_nettype wire
